// ===== rtl/crc16rfc_pkg.sv =====
// Shared constants, types and the CRC table function for the read frame checker.
package crc16rfc_pkg;

    localparam int FRAME_BYTES_DEF = 16;

    localparam logic [7:0]  CRC_HIGH_INIT = 8'h3C;
    localparam logic [7:0]  CRC_LOW_INIT  = 8'h7F;
    localparam logic [7:0]  HEADER_BYTE   = 8'hAA;
    localparam logic [1:0]  FLAGS_TOP     = 2'b10;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam int          ID_W          = 6;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_HEADER = 2'd1,
        STATUS_BAD_FLAGS  = 2'd2,
        STATUS_CRC_ERROR  = 2'd3
    } status_t;

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  msg_id;
    } result_t;

    // Low byte is the high-table value, high byte is the low-table value.
    function automatic logic [15:0] crc_table_entry(input logic [7:0] v);
        logic [15:0] c;
        c = {8'h00, v};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc16rfc_core.sv =====
// Frame position tracking, CRC folding and frame checks for one registered byte.
module crc16rfc_core
    import crc16rfc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] frame_byte,
    input  logic       start_req,
    output logic       res_valid,
    output result_t    res
);

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_CHECK_HIGH = POS_W'(FRAME_BYTES - 2);

    logic [POS_W-1:0] pos_reg, pos_next, pos_cur;
    logic [7:0]       crc_high_reg, crc_high_next, crc_high_cur;
    logic [7:0]       crc_low_reg, crc_low_next, crc_low_cur;
    logic             header_ok_reg, header_ok_next;
    logic             flags_ok_reg, flags_ok_next;
    logic [ID_W-1:0]  saved_id_reg, saved_id_next;
    logic             first_match_reg, first_match_next;
    logic [15:0]      table_val;

    always_comb
    begin
        pos_cur      = start_req ? '0 : pos_reg;
        crc_high_cur = (pos_cur == '0) ? CRC_HIGH_INIT : crc_high_reg;
        crc_low_cur  = (pos_cur == '0) ? CRC_LOW_INIT : crc_low_reg;
        table_val    = crc_table_entry(crc_high_cur ^ frame_byte);

        header_ok_next   = header_ok_reg;
        flags_ok_next    = flags_ok_reg;
        saved_id_next    = saved_id_reg;
        first_match_next = first_match_reg;
        if (pos_cur == '0)
        begin
            header_ok_next = (frame_byte == HEADER_BYTE);
        end
        if (pos_cur == POS_W'(1))
        begin
            flags_ok_next = (frame_byte[7:6] == FLAGS_TOP);
            saved_id_next = frame_byte[ID_W-1:0];
        end

        res_valid    = 1'b0;
        res.status   = STATUS_OK;
        res.msg_id   = '0;
        crc_high_next = crc_high_cur;
        crc_low_next  = crc_low_cur;
        priority if (pos_cur < POS_CHECK_HIGH)
        begin
            crc_high_next = crc_low_cur ^ table_val[7:0];
            crc_low_next  = table_val[15:8];
            pos_next      = pos_cur + POS_W'(1);
        end
        else if (pos_cur == POS_CHECK_HIGH)
        begin
            first_match_next = (frame_byte == crc_high_cur);
            pos_next         = pos_cur + POS_W'(1);
        end
        else
        begin
            res_valid = 1'b1;
            priority if (!header_ok_reg)
            begin
                res.status = STATUS_BAD_HEADER;
            end
            else if (!flags_ok_reg)
            begin
                res.status = STATUS_BAD_FLAGS;
            end
            else if (!first_match_reg || (frame_byte != crc_low_cur))
            begin
                res.status = STATUS_CRC_ERROR;
            end
            else
            begin
                res.status = STATUS_OK;
                res.msg_id = saved_id_reg;
            end
            pos_next      = '0;
            crc_high_next = CRC_HIGH_INIT;
            crc_low_next  = CRC_LOW_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            crc_high_reg    <= CRC_HIGH_INIT;
            crc_low_reg     <= CRC_LOW_INIT;
            header_ok_reg   <= 1'b0;
            flags_ok_reg    <= 1'b0;
            saved_id_reg    <= '0;
            first_match_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg         <= pos_next;
            crc_high_reg    <= crc_high_next;
            crc_low_reg     <= crc_low_next;
            header_ok_reg   <= header_ok_next;
            flags_ok_reg    <= flags_ok_next;
            saved_id_reg    <= saved_id_next;
            first_match_reg <= first_match_next;
        end
    end

endmodule

// ===== rtl/crc16rfc_outq.sv =====
// Output result register with valid and stall handshake.
module crc16rfc_outq
    import crc16rfc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  result_t         load_data,
    output logic            free,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      status,
    output logic [ID_W-1:0] msg_id
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign status    = data_reg.status;
    assign msg_id    = data_reg.msg_id;

endmodule

// ===== rtl/crc16_read_frame_checker.sv =====
// Top level of the CRC-16 read frame checker: input register, checker core and output register.
// The checker takes one word per cycle, each word being one frame byte, and gives one result
// word after the last byte of every frame of FRAME_BYTES bytes. A word is held in an input
// register, where a single table step of the CRC and the frame checks run, and a result is
// loaded into the output register when that step is taken on the last byte of a frame, so a
// result passes from the input register to the output register. The input stalls only while
// a result waits in a stalled output register and the registered byte would produce another
// one; otherwise a word is accepted every cycle. A raised start_req makes its byte the first
// of a new frame.
module crc16_read_frame_checker
    import crc16rfc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      frame_byte,
    input  logic            start_req,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      status,
    output logic [ID_W-1:0] msg_id
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       in_accept;
    logic       s1_go;
    logic       res_valid;
    result_t    res;
    logic       out_free;

    assign s1_go     = s1_valid_reg && (!res_valid || out_free);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else
        begin
            s1_valid_next = s1_valid_reg && !s1_go;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg  <= frame_byte;
            s1_start_reg <= start_req;
        end
    end

    crc16rfc_core #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_go),
        .frame_byte (s1_byte_reg),
        .start_req  (s1_start_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    crc16rfc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_go && res_valid),
        .load_data (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .msg_id    (msg_id)
    );

`ifndef SYNTHESIS
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && res_valid && out_valid && out_stall))
        else $error("input stalled without a blocked result");

    a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && res_valid) |=> (out_valid && (status == $past(res.status))
            && (msg_id == $past(res.msg_id))))
        else $error("result word not loaded into the output register");

    a_id_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status != STATUS_OK)) |-> (res.msg_id == '0))
        else $error("message id not cleared on a failed frame");
`endif

endmodule
